// ===== sv/mtep_pkg.sv =====
package mtep_pkg;

	// Widths of the event fields.
	localparam int DELTA_W = 28;
	localparam int BYTE_W = 8;
	localparam int M_TDATA_W = 64;

	// Default limit on the number of delta-time bytes.
	localparam int MAX_DELTA_BYTES_DEF = 4;

	// Result kinds carried on the output tuser.
	typedef enum logic [1:0] {
		KIND_CHANNEL = 2'd0,
		KIND_META_HDR = 2'd1,
		KIND_META_PAY = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	// Error causes.
	typedef enum logic [1:0] {
		CAUSE_UNSUPPORTED = 2'd0,
		CAUSE_DELTA_LONG = 2'd1,
		CAUSE_TRACK_END = 2'd2
	} cause_t;

	// Bit positions of the output tdata fields.
	localparam int OD_DELTA_LO = 0;
	localparam int OD_STATUS_LO = 28;
	localparam int OD_P1_LO = 36;
	localparam int OD_P2_LO = 44;
	localparam int OD_PAY_LO = 52;
	localparam int OD_CAUSE_LO = 60;
	localparam int OD_PAD_LO = 62;

endpackage

// ===== sv/midi_track_event_parser.sv =====
// Track event parser for MIDI track data. It takes one byte per request and
// gives at most one result per byte: a channel event when its last parameter
// arrives, a meta header when the meta length arrives, one result per meta
// payload byte, or an error (unsupported system status, a delta longer than
// MAX_DELTA_BYTES bytes, or a track that ends mid-event). After an error no
// results come until a byte with track_begin set. A byte passes an input
// register and one step of the parse state machine into the output register,
// and one byte is accepted every cycle as long as the output side takes
// results; a new byte can still enter an empty input register while a
// result waits.
module midi_track_event_parser
	import mtep_pkg::*;
#(
	parameter int MAX_DELTA_BYTES = MAX_DELTA_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [BYTE_W-1:0]    s_tdata,  // [7:0] data_byte
	input  logic                 s_tuser,  // [0] track_begin
	input  logic                 s_tlast,  // track_final
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [27:0] delta_time, [35:28] event_status, [43:36] first_param,
	// [51:44] second_param, [59:52] payload_byte, [61:60] error_cause,
	// [63:62] zero
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [1:0]           m_tuser,  // [1:0] result_kind
	output logic                 m_tlast   // end_of_event
);

	localparam int CntW = $clog2(MAX_DELTA_BYTES + 1);

	typedef enum logic [2:0] {
		PH_DELTA,
		PH_STATUS,
		PH_P1,
		PH_P2,
		PH_MTYPE,
		PH_MLEN,
		PH_MPAY
	} phase_t;

	// Input stage.
	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              begin_s1;
	logic              final_s1;

	// Parser state.
	phase_t             phase_q;
	logic [DELTA_W-1:0] delta_q;
	logic [CntW-1:0]    cnt_q;
	logic [BYTE_W-1:0]  status_q;
	logic [BYTE_W-1:0]  param_q;
	logic [BYTE_W-1:0]  left_q;
	logic               err_q;

	// Output register.
	logic               out_valid_q;
	kind_t              out_kind_q;
	logic [DELTA_W-1:0] out_delta_q;
	logic [BYTE_W-1:0]  out_status_q;
	logic [BYTE_W-1:0]  out_p1_q;
	logic [BYTE_W-1:0]  out_p2_q;
	logic [BYTE_W-1:0]  out_pay_q;
	cause_t             out_cause_q;
	logic               out_eoe_q;

	// Next state and result of the byte in the input stage.
	phase_t             nxt_phase;
	logic [DELTA_W-1:0] nxt_delta;
	logic [CntW-1:0]    nxt_cnt;
	logic [BYTE_W-1:0]  nxt_status;
	logic [BYTE_W-1:0]  nxt_param;
	logic [BYTE_W-1:0]  nxt_left;
	logic               nxt_err;
	logic [DELTA_W-1:0] cur_delta;
	logic [CntW-1:0]    cnt_upd;
	logic [BYTE_W-1:0]  left_upd;
	logic               ended;
	logic               res_valid;
	kind_t              res_kind;
	logic [DELTA_W-1:0] res_delta;
	logic [BYTE_W-1:0]  res_p1;
	logic [BYTE_W-1:0]  res_p2;
	logic [BYTE_W-1:0]  res_pay;
	cause_t             res_cause;
	logic               res_eoe;
	logic               adv;

	// The input stage moves on when the output register is free or drained.
	assign adv = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// One parse step; a track_begin byte sees cleared state.
	always_comb begin
		nxt_phase = begin_s1 ? PH_DELTA : phase_q;
		nxt_delta = begin_s1 ? '0 : delta_q;
		nxt_cnt = begin_s1 ? '0 : cnt_q;
		nxt_status = begin_s1 ? '0 : status_q;
		nxt_param = begin_s1 ? '0 : param_q;
		nxt_left = begin_s1 ? '0 : left_q;
		nxt_err = begin_s1 ? 1'b0 : err_q;
		cur_delta = nxt_delta;
		cnt_upd = nxt_cnt + CntW'(1);
		left_upd = nxt_left - BYTE_W'(1);
		ended = 1'b0;
		res_valid = 1'b0;
		res_kind = KIND_CHANNEL;
		res_delta = nxt_delta;
		res_p1 = '0;
		res_p2 = '0;
		res_pay = '0;
		res_cause = CAUSE_UNSUPPORTED;
		res_eoe = 1'b0;
		if (!nxt_err) begin
			case (nxt_phase)
				PH_DELTA: begin
					cur_delta = {nxt_delta[DELTA_W-8:0], data_s1[6:0]};
					nxt_delta = cur_delta;
					nxt_cnt = cnt_upd;
					if (!data_s1[7]) begin
						nxt_phase = PH_STATUS;
					end else if (cnt_upd >= CntW'(MAX_DELTA_BYTES)) begin
						res_valid = 1'b1;
						res_kind = KIND_ERROR;
						res_cause = CAUSE_DELTA_LONG;
						res_eoe = 1'b1;
						nxt_err = 1'b1;
					end
				end
				PH_STATUS: begin
					nxt_status = data_s1;
					if (data_s1 == 8'hFF) begin
						nxt_phase = PH_MTYPE;
					end else if (data_s1 >= 8'hF0) begin
						res_valid = 1'b1;
						res_kind = KIND_ERROR;
						res_cause = CAUSE_UNSUPPORTED;
						res_eoe = 1'b1;
						nxt_err = 1'b1;
					end else begin
						nxt_phase = PH_P1;
					end
				end
				PH_P1: begin
					if (nxt_status inside {[8'h80:8'hBF], [8'hE0:8'hEF]}) begin
						nxt_param = data_s1;
						nxt_phase = PH_P2;
					end else begin
						res_valid = 1'b1;
						res_p1 = data_s1;
						res_eoe = 1'b1;
						ended = 1'b1;
					end
				end
				PH_P2: begin
					res_valid = 1'b1;
					res_p1 = nxt_param;
					res_p2 = data_s1;
					res_eoe = 1'b1;
					ended = 1'b1;
				end
				PH_MTYPE: begin
					nxt_param = data_s1;
					nxt_phase = PH_MLEN;
				end
				PH_MLEN: begin
					nxt_left = data_s1;
					res_valid = 1'b1;
					res_kind = KIND_META_HDR;
					res_p1 = nxt_param;
					res_p2 = data_s1;
					res_eoe = (data_s1 == '0);
					ended = (data_s1 == '0);
					nxt_phase = PH_MPAY;
				end
				default: begin
					nxt_left = left_upd;
					res_valid = 1'b1;
					res_kind = KIND_META_PAY;
					res_p1 = nxt_param;
					res_pay = data_s1;
					res_eoe = (left_upd == '0);
					ended = (left_upd == '0);
				end
			endcase
			res_delta = cur_delta;
			// A track that stops before the event is complete is an error.
			if (final_s1 && !ended && !nxt_err) begin
				res_valid = 1'b1;
				res_kind = KIND_ERROR;
				res_p1 = '0;
				res_p2 = '0;
				res_pay = '0;
				res_cause = CAUSE_TRACK_END;
				res_eoe = 1'b1;
				nxt_err = 1'b1;
			end
			if (ended) begin
				nxt_phase = PH_DELTA;
				nxt_delta = '0;
				nxt_cnt = '0;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			begin_s1 <= s_tuser;
			final_s1 <= s_tlast;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			delta_q <= '0;
			cnt_q <= '0;
			status_q <= '0;
			param_q <= '0;
			left_q <= '0;
			err_q <= 1'b0;
		end else if (adv) begin
			phase_q <= nxt_phase;
			delta_q <= nxt_delta;
			cnt_q <= nxt_cnt;
			status_q <= nxt_status;
			param_q <= nxt_param;
			left_q <= nxt_left;
			err_q <= nxt_err;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_kind_q <= res_kind;
			out_delta_q <= res_delta;
			out_status_q <= nxt_status;
			out_p1_q <= res_p1;
			out_p2_q <= res_p2;
			out_pay_q <= res_pay;
			out_cause_q <= res_cause;
			out_eoe_q <= res_eoe;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_kind_q;
	assign m_tlast = out_eoe_q;
	assign m_tdata = {2'b00, out_cause_q, out_pay_q, out_p2_q, out_p1_q, out_status_q,
		out_delta_q};

endmodule

// ===== sv/mtep_checker.sv =====
module mtep_checker
	import mtep_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [1:0]           m_tuser,
	input logic                 m_tlast
);

	// A stalled result holds its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// Errors and channel events always close their event.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_ERROR || m_tuser == KIND_CHANNEL) |-> m_tlast)
		else $error("error or channel event without end of event");

	// Only errors carry a cause.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_ERROR |-> m_tdata[OD_CAUSE_LO+1:OD_CAUSE_LO] == '0)
		else $error("cause set on a non-error result");

	// Parameters and payload are zero in an error.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_ERROR |-> m_tdata[OD_CAUSE_LO-1:OD_P1_LO] == '0)
		else $error("error result with nonzero parameters");

	// Padding bits stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:OD_PAD_LO] == '0)
		else $error("tdata padding not zero");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (.*);
